FILE: hw/rtl/mdlg_pkg.sv
// ----------------------------------------------------------------------------
// mdlg_pkg
// Types and constants shared by the motor drive lease guard modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mdlg_pkg;

    typedef enum logic [1:0] {
        OP_ARM     = 2'd0,
        OP_HOLD    = 2'd1,
        OP_SERVICE = 2'd2,
        OP_UNUSED  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_REJECT = 3'd1,
        ACT_OFF    = 3'd2,
        ACT_WAKE   = 3'd3,
        ACT_RUN    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WAKING = 2'd1,
        PH_ACTIVE = 2'd2,
        PH_ENDED  = 2'd3
    } phase_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SESSION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LEASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY    = 3'd4;

    localparam logic [31:0] MAX_SESSION_RST = 32'd30000;
    localparam logic [31:0] HOLD_LEASE_RST  = 32'd200;
    localparam logic [31:0] WAKE_DELAY_RST  = 32'd50;
    localparam logic [9:0]  MIN_DUTY_RST    = 10'd1;
    localparam logic [9:0]  MAX_DUTY_RST    = 10'd1000;

    localparam logic signed [7:0] DIR_FWD = 8'sd1;
    localparam logic signed [7:0] DIR_REV = -8'sd1;

    typedef struct packed {
        logic [31:0] max_session_ms;
        logic [31:0] hold_lease_ms;
        logic [31:0] wake_delay_ms;
        logic [9:0]  min_duty;
        logic [9:0]  max_duty;
    } cfg_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [31:0]        now_ms;
        logic [31:0]        session_gen;
        logic [7:0]         req_channel;
        logic signed [7:0]  req_direction;
        logic [15:0]        req_duty;
    } item_t;

    // Session state apart from the locked channel, whose width follows the
    // channel count.
    typedef struct packed {
        logic               armed_flag;
        phase_t             phase;
        logic [31:0]        armed_time;
        logic [31:0]        last_hold_time;
        logic [31:0]        wake_time;
        logic [31:0]        session_id;
        logic signed [1:0]  locked_direction;
        logic [9:0]         locked_duty;
    } state_t;

    typedef struct packed {
        action_t            action;
        phase_t             phase_now;
        logic               is_fresh;
        logic [1:0]         drive_channel;
        logic signed [1:0]  drive_direction;
        logic [9:0]         drive_duty;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mdlg_step.sv
// ----------------------------------------------------------------------------
// mdlg_step
// Next-state and result logic for one item of the lease guard.
// ----------------------------------------------------------------------------
`default_nettype none

module mdlg_step #(
    parameter int CHANNEL_COUNT = 4,
    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
    input  mdlg_pkg::cfg_t    cfg,
    input  mdlg_pkg::item_t   item,
    input  mdlg_pkg::state_t  state,
    input  logic [CH_W-1:0]   locked_channel,
    output mdlg_pkg::state_t  state_next,
    output logic [CH_W-1:0]   locked_channel_next,
    output mdlg_pkg::result_t result
);
    import mdlg_pkg::*;

    logic [31:0] age;
    logic [31:0] hold_gap;
    logic [31:0] wake_gap;
    logic        age_ok;
    logic        lease_ok;
    logic        wake_done;
    logic        id_match;
    logic        busy;
    logic        on_lease;
    logic        fresh_pre;
    logic        ch_ok;
    logic        dir_zero;
    logic        dir_run;
    logic        duty_ok;
    logic        zero_req;
    logic        run_req;
    logic        ch_match;
    logic        dir_match;
    logic        duty_match;
    logic        renewed;
    logic        reject;
    action_t     act;
    logic [7:0]  ch_wide;

    // The three time windows are checked side by side on wrapped differences.
    assign age       = item.now_ms - state.armed_time;
    assign hold_gap  = item.now_ms - state.last_hold_time;
    assign wake_gap  = item.now_ms - state.wake_time;
    assign age_ok    = age <= cfg.max_session_ms;
    assign lease_ok  = hold_gap <= cfg.hold_lease_ms;
    assign wake_done = wake_gap >= cfg.wake_delay_ms;
    assign id_match  = state.session_id == item.session_gen;
    assign busy      = state.phase != PH_IDLE;
    assign on_lease  = (state.phase == PH_WAKING) || (state.phase == PH_ACTIVE);
    assign fresh_pre = state.armed_flag && id_match && age_ok && (!on_lease || lease_ok);

    assign ch_ok    = {1'b0, item.req_channel} < 9'(CHANNEL_COUNT);
    assign dir_zero = item.req_direction == 8'sd0;
    assign dir_run  = (item.req_direction == DIR_FWD) || (item.req_direction == DIR_REV);
    assign duty_ok  = (item.req_duty >= {6'd0, cfg.min_duty}) &&
                      (item.req_duty <= {6'd0, cfg.max_duty});
    assign zero_req = ch_ok && dir_zero && (item.req_duty == 16'd0);
    assign run_req  = ch_ok && dir_run && duty_ok;

    assign ch_match   = item.req_channel[CH_W-1:0] == locked_channel;
    assign dir_match  = item.req_direction[1:0] == state.locked_direction;
    assign duty_match = item.req_duty == {6'd0, state.locked_duty};

    always_comb
    begin
        state_next          = state;
        locked_channel_next = locked_channel;
        act                 = ACT_NONE;
        reject              = 1'b0;
        renewed             = 1'b0;

        unique case (item.opcode)
            OP_ARM:
            begin
                state_next                  = '0;
                state_next.phase            = PH_IDLE;
                state_next.armed_flag       = 1'b1;
                state_next.armed_time       = item.now_ms;
                state_next.last_hold_time   = item.now_ms;
                state_next.session_id       = item.session_gen;
                locked_channel_next         = '0;
            end
            OP_HOLD:
            begin
                if (!fresh_pre || !(zero_req || run_req))
                begin
                    reject = 1'b1;
                end
                else if (busy && !ch_match)
                begin
                    reject = 1'b1;
                end
                else if (run_req && busy && (!dir_match || !duty_match))
                begin
                    reject = 1'b1;
                end
                else if (zero_req)
                begin
                    if (busy && state.phase != PH_ENDED)
                    begin
                        state_next.phase = PH_ENDED;
                        act              = ACT_OFF;
                    end
                end
                else if (state.phase == PH_ENDED)
                begin
                    reject = 1'b1;
                end
                else
                begin
                    renewed                   = 1'b1;
                    state_next.last_hold_time = item.now_ms;
                    if (!busy)
                    begin
                        locked_channel_next         = item.req_channel[CH_W-1:0];
                        state_next.locked_direction = item.req_direction[1:0];
                        state_next.locked_duty      = item.req_duty[9:0];
                        state_next.phase            = PH_WAKING;
                        state_next.wake_time        = item.now_ms;
                        act                         = ACT_WAKE;
                    end
                end
            end
            OP_SERVICE:
            begin
                if (state.armed_flag)
                begin
                    if (state.phase == PH_ENDED)
                    begin
                        reject = !age_ok;
                    end
                    else if (!fresh_pre)
                    begin
                        reject = 1'b1;
                    end
                    else if (state.phase == PH_WAKING && wake_done)
                    begin
                        state_next.phase = PH_ACTIVE;
                        act              = ACT_RUN;
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase

        if (reject)
        begin
            state_next.armed_flag = 1'b0;
            state_next.phase      = PH_ENDED;
            act                   = ACT_REJECT;
        end
    end

    assign ch_wide = 8'(locked_channel_next);

    always_comb
    begin
        result.action          = act;
        result.phase_now       = state_next.phase;
        // Arming always leaves a fresh session; otherwise the arm time and
        // generation are unchanged and a renewed hold restarts the lease.
        if (item.opcode == OP_ARM)
        begin
            result.is_fresh = 1'b1;
        end
        else
        begin
            result.is_fresh = state_next.armed_flag && id_match && age_ok &&
                              (!((state_next.phase == PH_WAKING) ||
                                 (state_next.phase == PH_ACTIVE)) ||
                               renewed || lease_ok);
        end
        result.drive_channel   = ch_wide[1:0];
        result.drive_direction = state_next.locked_direction;
        result.drive_duty      = state_next.locked_duty;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/motor_drive_lease_guard.sv
// An input beat is registered in the input register, evaluated combinationally,
// and its result beat is registered in the result register for the master side.
// Throughput: one item per cycle unless the master side stalls; the session state
// is updated in the same cycle that the result register loads, so the next item sees it at once.
// Reset clears the session state, empties both registers and restores the
// configuration registers to their default values.
// ----------------------------------------------------------------------------
// motor_drive_lease_guard
// Session lease guard for a slow motor drive with a stream interface.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_drive_lease_guard #(
    parameter int CHANNEL_COUNT = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mdlg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                      cfg_data,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // now_ms[31:0], session_gen[63:32], req_channel[71:64],
    // req_direction[79:72], req_duty[95:80]
    input  logic [95:0]                      s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]                       s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // phase_now[1:0], is_fresh[2], drive_channel[4:3], drive_direction[6:5],
    // drive_duty[16:7], zero[23:17]
    output logic [23:0]                      m_axis_tdata,
    // action[2:0]
    output logic [2:0]                       m_axis_tuser
);
    import mdlg_pkg::*;

    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    cfg_t              cfg_reg;
    state_t            state_reg;
    state_t            state_next;
    logic [CH_W-1:0]   locked_channel_reg;
    logic [CH_W-1:0]   locked_channel_next;
    item_t             in_reg;
    logic              in_valid_reg;
    result_t           out_reg;
    result_t           result;
    logic              out_valid_reg;
    logic              step_en;
    logic              in_take;
    item_t             in_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_session_ms <= MAX_SESSION_RST;
            cfg_reg.hold_lease_ms  <= HOLD_LEASE_RST;
            cfg_reg.wake_delay_ms  <= WAKE_DELAY_RST;
            cfg_reg.min_duty       <= MIN_DUTY_RST;
            cfg_reg.max_duty       <= MAX_DUTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_SESSION: cfg_reg.max_session_ms <= cfg_data;
                CFG_HOLD_LEASE:  cfg_reg.hold_lease_ms  <= cfg_data;
                CFG_WAKE_DELAY:  cfg_reg.wake_delay_ms  <= cfg_data;
                CFG_MIN_DUTY:    cfg_reg.min_duty       <= cfg_data[9:0];
                CFG_MAX_DUTY:    cfg_reg.max_duty       <= cfg_data[9:0];
                default:         cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // The input register advances whenever the result register can take
    // the item it holds.
    assign step_en       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step_en;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign in_item.opcode        = opcode_t'(s_axis_tuser[1:0]);
    assign in_item.now_ms        = s_axis_tdata[31:0];
    assign in_item.session_gen   = s_axis_tdata[63:32];
    assign in_item.req_channel   = s_axis_tdata[71:64];
    assign in_item.req_direction = s_axis_tdata[79:72];
    assign in_item.req_duty      = s_axis_tdata[95:80];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= in_item;
        end
    end

    mdlg_step #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_step (
        .cfg                 (cfg_reg),
        .item                (in_reg),
        .state               (state_reg),
        .locked_channel      (locked_channel_reg),
        .state_next          (state_next),
        .locked_channel_next (locked_channel_next),
        .result              (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= '0;
            locked_channel_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (step_en)
            begin
                state_reg          <= state_next;
                locked_channel_reg <= locked_channel_next;
                out_valid_reg      <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.action;
    assign m_axis_tdata  = {7'd0, out_reg.drive_duty, out_reg.drive_direction,
                            out_reg.drive_channel, out_reg.is_fresh, out_reg.phase_now};

    // A reject always disarms, so the session cannot read as fresh.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.action == ACT_REJECT) |->
            (out_reg.phase_now == PH_ENDED && !out_reg.is_fresh))
        else $error("reject result without ended phase or with fresh session");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.action == ACT_WAKE) |->
            (out_reg.phase_now == PH_WAKING && out_reg.is_fresh))
        else $error("wake result not in waking phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.action == ACT_RUN) |-> (out_reg.phase_now == PH_ACTIVE))
        else $error("run result not in active phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> (out_valid_reg && state_reg == $past(state_next)))
        else $error("evaluated item did not reach result register and state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step_en) |=> (in_valid_reg && $stable(in_reg)))
        else $error("held input item lost while result side stalled");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the motor drive lease guard. Arm, hold and service
// beats are driven with random gaps and output stalls while a local copy of
// the session state predicts each result; every result beat is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;

    import mdlg_pkg::*;

    localparam int CHANNELS        = 4;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int REPORT_LIMIT    = 100;
    localparam int ITEMS_PER_SETUP = 100;

    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [31:0]          cfg_data       = '0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [95:0]          s_axis_tdata   = '0;
    logic [1:0]           s_axis_tuser   = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b0;
    logic [23:0]          m_axis_tdata;
    logic [2:0]           m_axis_tuser;

    motor_drive_lease_guard #(
        .CHANNEL_COUNT(CHANNELS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Local copy of the configuration and of the session state.
    cfg_t              guard_cfg;
    logic              armed;
    phase_t            drive_phase;
    logic [31:0]       armed_at;
    logic [31:0]       last_hold_at;
    logic [31:0]       wake_at;
    logic [31:0]       session_no;
    logic [7:0]        lock_channel;
    logic signed [7:0] lock_direction;
    logic [9:0]        lock_duty;

    result_t     expected_results[$];
    result_t     want_r;
    result_t     got_r;
    int          mismatch_count     = 0;
    int          items_sent         = 0;
    int          idle_cycles        = 0;
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;
    logic [31:0] wall_ms;
    logic [31:0] gen_r;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic session_valid(input logic [31:0] now_v, input logic [31:0] gen);
        logic [31:0] age;
        logic [31:0] since_hold;
        age        = now_v - armed_at;
        since_hold = now_v - last_hold_at;
        if (!armed || session_no != gen)
            return 1'b0;
        if (age > guard_cfg.max_session_ms)
            return 1'b0;
        if ((drive_phase == PH_WAKING || drive_phase == PH_ACTIVE) &&
            since_hold > guard_cfg.hold_lease_ms)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic action_t end_drive();
        armed       = 1'b0;
        drive_phase = PH_ENDED;
        return ACT_REJECT;
    endfunction

    function automatic void clear_session();
        armed          = 1'b0;
        drive_phase    = PH_IDLE;
        armed_at       = '0;
        last_hold_at   = '0;
        wake_at        = '0;
        session_no     = '0;
        lock_channel   = '0;
        lock_direction = '0;
        lock_duty      = '0;
    endfunction

    // Computes the result beat of one accepted item and advances the session.
    function automatic result_t predict_guard(input item_t it);
        result_t     r;
        action_t     act;
        logic        ch_ok;
        logic        zero_req;
        logic        run_req;
        logic        busy;
        logic [31:0] age;
        logic [31:0] waited;
        act      = ACT_NONE;
        ch_ok    = it.req_channel < CHANNELS;
        zero_req = ch_ok && it.req_direction == 0 && it.req_duty == 0;
        run_req  = ch_ok && (it.req_direction == DIR_REV || it.req_direction == DIR_FWD) &&
                   it.req_duty >= {6'd0, guard_cfg.min_duty} &&
                   it.req_duty <= {6'd0, guard_cfg.max_duty};
        busy     = drive_phase != PH_IDLE;
        age      = it.now_ms - armed_at;
        waited   = it.now_ms - wake_at;
        case (it.opcode)
            OP_ARM:
            begin
                clear_session();
                armed        = 1'b1;
                armed_at     = it.now_ms;
                last_hold_at = it.now_ms;
                session_no   = it.session_gen;
            end
            OP_HOLD:
            begin
                if (!session_valid(it.now_ms, it.session_gen) || !(zero_req || run_req))
                    act = end_drive();
                else if (busy && (it.req_channel != lock_channel ||
                         (run_req && (it.req_direction != lock_direction ||
                                      it.req_duty != {6'd0, lock_duty}))))
                    act = end_drive();
                else if (zero_req)
                begin
                    if (busy && drive_phase != PH_ENDED)
                    begin
                        drive_phase = PH_ENDED;
                        act         = ACT_OFF;
                    end
                end
                else if (drive_phase == PH_ENDED)
                    act = end_drive();
                else
                begin
                    last_hold_at = it.now_ms;
                    if (drive_phase == PH_IDLE)
                    begin
                        lock_channel   = it.req_channel;
                        lock_direction = it.req_direction;
                        lock_duty      = it.req_duty[9:0];
                        drive_phase    = PH_WAKING;
                        wake_at        = it.now_ms;
                        act            = ACT_WAKE;
                    end
                end
            end
            OP_SERVICE:
            begin
                if (!armed)
                    act = ACT_NONE;
                else if (drive_phase == PH_ENDED)
                begin
                    if (age > guard_cfg.max_session_ms)
                        act = end_drive();
                end
                else if (!session_valid(it.now_ms, it.session_gen))
                    act = end_drive();
                else if (drive_phase == PH_WAKING && waited >= guard_cfg.wake_delay_ms)
                begin
                    drive_phase = PH_ACTIVE;
                    act         = ACT_RUN;
                end
            end
            default:
            begin
            end
        endcase
        r.action          = act;
        r.phase_now       = drive_phase;
        r.is_fresh        = session_valid(it.now_ms, it.session_gen);
        r.drive_channel   = lock_channel[1:0];
        r.drive_direction = lock_direction[1:0];
        r.drive_duty      = lock_duty;
        return r;
    endfunction

    function automatic item_t make_item(input opcode_t op, input logic [31:0] now_v,
                                        input logic [31:0] gen, input logic [7:0] ch,
                                        input logic signed [7:0] dir, input logic [15:0] duty);
        item_t it;
        it.opcode        = op;
        it.now_ms        = now_v;
        it.session_gen   = gen;
        it.req_channel   = ch;
        it.req_direction = dir;
        it.req_duty      = duty;
        return it;
    endfunction

    // Sends one beat after a random gap and records its prediction once taken.
    task automatic send_item(input item_t it);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.req_duty, it.req_direction, it.req_channel,
                          it.session_gen, it.now_ms};
        s_axis_tuser  <= it.opcode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_results.push_back(predict_guard(it));
        if (it.opcode != OP_UNUSED)
            items_sent++;
    endtask

    task automatic send_arm(input logic [31:0] now_v, input logic [31:0] gen);
        send_item(make_item(OP_ARM, now_v, gen, 8'd0, 8'sd0, 16'd0));
    endtask

    task automatic send_hold(input logic [31:0] now_v, input logic [31:0] gen,
                             input logic [7:0] ch, input logic signed [7:0] dir,
                             input logic [15:0] duty);
        send_item(make_item(OP_HOLD, now_v, gen, ch, dir, duty));
    endtask

    task automatic send_service(input logic [31:0] now_v, input logic [31:0] gen);
        send_item(make_item(OP_SERVICE, now_v, gen, 8'd0, 8'sd0, 16'd0));
    endtask

    // Holds the input side until every predicted result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MAX_SESSION: guard_cfg.max_session_ms = value;
            CFG_HOLD_LEASE:  guard_cfg.hold_lease_ms  = value;
            CFG_WAKE_DELAY:  guard_cfg.wake_delay_ms  = value;
            CFG_MIN_DUTY:    guard_cfg.min_duty       = value[9:0];
            CFG_MAX_DUTY:    guard_cfg.max_duty       = value[9:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic load_config(input cfg_t c);
        drain_results();
        write_reg(CFG_MAX_SESSION, c.max_session_ms);
        write_reg(CFG_HOLD_LEASE, c.hold_lease_ms);
        write_reg(CFG_WAKE_DELAY, c.wake_delay_ms);
        write_reg(CFG_MIN_DUTY, {22'd0, c.min_duty});
        write_reg(CFG_MAX_DUTY, {22'd0, c.max_duty});
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_r.action          = action_t'(m_axis_tuser);
            got_r.phase_now       = phase_t'(m_axis_tdata[1:0]);
            got_r.is_fresh        = m_axis_tdata[2];
            got_r.drive_channel   = m_axis_tdata[4:3];
            got_r.drive_direction = m_axis_tdata[6:5];
            got_r.drive_duty      = m_axis_tdata[16:7];
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                $error("result beat with no prediction pending: action %0d", got_r.action);
            end
            else
            begin
                want_r = expected_results.pop_front();
                check_field("action", want_r.action, got_r.action);
                check_field("phase_now", want_r.phase_now, got_r.phase_now);
                check_field("is_fresh", want_r.is_fresh, got_r.is_fresh);
                check_field("drive_channel", want_r.drive_channel, got_r.drive_channel);
                check_field("drive_direction", want_r.drive_direction, got_r.drive_direction);
                check_field("drive_duty", want_r.drive_duty, got_r.drive_duty);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Time step between items: mostly inside the lease, sometimes past the wake
    // delay or the lease, rarely far enough to expire the session.
    function automatic logic [31:0] next_gap();
        logic [31:0] lease_c;
        logic [31:0] wake_c;
        logic [31:0] session_c;
        int          r;
        lease_c   = (guard_cfg.hold_lease_ms > 400) ? 32'd400 : guard_cfg.hold_lease_ms;
        wake_c    = (guard_cfg.wake_delay_ms > 400) ? 32'd400 : guard_cfg.wake_delay_ms;
        session_c = (guard_cfg.max_session_ms > 40000) ? 32'd40000 : guard_cfg.max_session_ms;
        r         = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, lease_c);
        else if (r < 93)
            return $urandom_range(0, lease_c + wake_c + 20);
        else if (r < 98)
            return $urandom_range(0, session_c + 50);
        return $urandom;
    endfunction

    // One session: an arm beat and a run of holds and ticks that mostly follow
    // the protocol, mixed with off commands, foreign generations and noise.
    task automatic random_session();
        logic [7:0]        ch;
        logic signed [7:0] dir;
        logic [15:0]       duty;
        int                r;
        if ($urandom_range(0, 99) < 60)
            gen_r = $urandom;
        else
            gen_r = gen_r + 1;
        wall_ms = wall_ms + next_gap();
        send_arm(wall_ms, gen_r);
        ch  = $urandom_range(0, CHANNELS - 1);
        dir = $urandom_range(0, 1) ? DIR_FWD : DIR_REV;
        if (guard_cfg.min_duty <= guard_cfg.max_duty)
            duty = $urandom_range(guard_cfg.min_duty, guard_cfg.max_duty);
        else
            duty = $urandom_range(0, 1000);
        repeat ($urandom_range(1, 14))
        begin
            wall_ms = wall_ms + next_gap();
            r       = $urandom_range(0, 99);
            if (r < 45)
                send_hold(wall_ms, gen_r, ch, dir, duty);
            else if (r < 75)
                send_service(wall_ms, gen_r);
            else if (r < 82)
                send_hold(wall_ms, gen_r, ch, 8'sd0, 16'd0);
            else if (r < 85)
                send_hold(wall_ms, gen_r, $urandom_range(0, CHANNELS - 1), 8'sd0, 16'd0);
            else if (r < 88)
                send_service(wall_ms, $urandom_range(0, 1) ? $urandom : gen_r ^ 32'd1);
            else if (r < 91)
                send_hold(wall_ms, gen_r, $urandom_range(0, CHANNELS),
                          $signed(8'($urandom_range(0, 2)) - 8'd1), $urandom_range(0, 1023));
            else if (r < 94)
                send_hold(wall_ms, $urandom_range(0, 3) == 0 ? $urandom : gen_r,
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 65535));
            else if (r < 97)
                send_arm(wall_ms, gen_r);
            else
                send_item(make_item(OP_UNUSED, $urandom, $urandom, $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 65535)));
        end
    endtask

    task automatic test_directed_cases();
        logic [31:0] t;
        t = 32'hFFFF_FFC0;
        send_hold(t, 32'd0, 8'd0, DIR_FWD, 16'd10);
        send_service(t, 32'd0);
        send_item(make_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, -8'sd1, 16'hFFFF));
        // Waking to active across the 32-bit time wrap, then a changed duty.
        send_arm(t, 32'hFFFF_FFFF);
        send_hold(t + 1, 32'hFFFF_FFFF, 8'd3, DIR_REV, 16'd1000);
        send_hold(t + 40, 32'hFFFF_FFFF, 8'd3, DIR_REV, 16'd1000);
        send_service(t + 70, 32'hFFFF_FFFF);
        send_hold(t + 80, 32'hFFFF_FFFF, 8'd3, DIR_REV, 16'd999);
        send_service(t + 90, 32'hFFFF_FFFF);
        send_service(t + 40000, 32'hFFFF_FFFF);
        // Malformed requests, each on a fresh session.
        t = 32'd1000;
        send_arm(t, 32'd5);
        send_hold(t, 32'd5, 8'd0, 8'sd0, 16'd0);
        send_hold(t, 32'd5, 8'd0, 8'sd0, 16'd5);
        send_arm(t, 32'd5);
        send_hold(t, 32'd5, 8'd0, 8'sd2, 16'd10);
        send_arm(t, 32'd5);
        send_hold(t, 32'd5, 8'hFF, DIR_FWD, 16'd10);
        send_arm(t, 32'd5);
        send_hold(t, 32'd5, 8'd2, DIR_FWD, 16'hFFFF);
        // Off command on the locked channel, then holds after the drive ended.
        send_arm(t, 32'd6);
        send_hold(t + 1, 32'd6, 8'd1, DIR_FWD, 16'd500);
        send_hold(t + 2, 32'd6, 8'd1, 8'sd0, 16'd0);
        send_hold(t + 3, 32'd6, 8'd1, 8'sd0, 16'd0);
        send_hold(t + 4, 32'd6, 8'd1, DIR_FWD, 16'd500);
        // Zero command on another channel, a foreign generation, lease expiry.
        send_arm(t, 32'd7);
        send_hold(t + 1, 32'd7, 8'd1, DIR_FWD, 16'd500);
        send_hold(t + 2, 32'd7, 8'd2, 8'sd0, 16'd0);
        send_arm(t, 32'd8);
        send_hold(t + 1, 32'd9, 8'd0, DIR_FWD, 16'd1);
        send_arm(t, 32'd8);
        send_hold(t + 1, 32'd8, 8'd0, DIR_FWD, 16'd1);
        send_service(t + 300, 32'd8);
    endtask

    task automatic test_config_extremes();
        cfg_t c;
        c = '0;
        load_config(c);
        send_arm(32'd77, 32'd1);
        send_hold(32'd77, 32'd1, 8'd0, DIR_FWD, 16'd0);
        send_service(32'd77, 32'd1);
        send_hold(32'd78, 32'd1, 8'd0, DIR_FWD, 16'd0);
        c.max_session_ms = 32'hFFFF_FFFF;
        c.hold_lease_ms  = 32'hFFFF_FFFF;
        c.wake_delay_ms  = 32'hFFFF_FFFF;
        c.min_duty       = 10'd1000;
        c.max_duty       = 10'd1000;
        load_config(c);
        send_arm(32'd10, 32'hFFFF_FFFF);
        send_hold(32'd10, 32'hFFFF_FFFF, 8'd2, DIR_REV, 16'd1000);
        send_service(32'd15, 32'hFFFF_FFFF);
        send_service(32'd9, 32'hFFFF_FFFF);
        send_hold(32'd9, 32'hFFFF_FFFF, 8'd2, DIR_REV, 16'd999);
    endtask

    task automatic test_random_sessions(input int send_pct, input int recv_pct);
        cfg_t c;
        int   stop_at;
        drain_results();
        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        wall_ms            = $urandom;
        for (int k = 0; k < 4; k++)
        begin
            case (k)
                0:
                begin
                    c.max_session_ms = MAX_SESSION_RST;
                    c.hold_lease_ms  = HOLD_LEASE_RST;
                    c.wake_delay_ms  = WAKE_DELAY_RST;
                    c.min_duty       = MIN_DUTY_RST;
                    c.max_duty       = MAX_DUTY_RST;
                end
                1, 3:
                begin
                    c.max_session_ms = $urandom_range(200, 2000);
                    c.hold_lease_ms  = $urandom_range(1, 40);
                    c.wake_delay_ms  = $urandom_range(0, 60);
                    c.min_duty       = $urandom_range(0, 500);
                    c.max_duty       = $urandom_range(c.min_duty, 1000);
                end
                default:
                begin
                    c.max_session_ms = $urandom;
                    c.hold_lease_ms  = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300);
                    c.wake_delay_ms  = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300);
                    c.min_duty       = $urandom_range(0, 1000);
                    c.max_duty       = $urandom_range(0, 1000);
                end
            endcase
            load_config(c);
            stop_at = items_sent + ITEMS_PER_SETUP;
            while (items_sent < stop_at)
                random_session();
        end
    endtask

    initial
    begin
        guard_cfg.max_session_ms = MAX_SESSION_RST;
        guard_cfg.hold_lease_ms  = HOLD_LEASE_RST;
        guard_cfg.wake_delay_ms  = WAKE_DELAY_RST;
        guard_cfg.min_duty       = MIN_DUTY_RST;
        guard_cfg.max_duty       = MAX_DUTY_RST;
        clear_session();
        gen_r   = '0;
        wall_ms = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_config_extremes();
        test_random_sessions(0, 0);
        test_random_sessions(85, 0);
        test_random_sessions(0, 85);
        test_random_sessions(8, 8);

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: motor_drive_lease_guard.f
hw/rtl/mdlg_pkg.sv
hw/rtl/mdlg_step.sv
hw/rtl/motor_drive_lease_guard.sv
test/testbench.sv
